/* design/tcce_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types, constants and helpers of the text console cursor engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

   // screen geometry
   localparam int COLUMNS      = 80;
   localparam int SCROLL_ROWS  = 24;
   localparam int SCREEN_CELLS = 2000;

   // field widths
   localparam int COL_W   = 7;
   localparam int ROW_W   = 5;
   localparam int CELL_AW = $clog2(SCREEN_CELLS);
   localparam int IDX_W   = COL_W + ROW_W;

   // sweep bounds
   localparam int MOVE_CELLS = (SCROLL_ROWS - 1) * COLUMNS;
   localparam int BLANK_END  = SCROLL_ROWS * COLUMNS - 1;
   localparam int LAST_CELL  = SCREEN_CELLS - 1;
   localparam int TAB_STOP   = 8;

   // request op codes
   localparam logic [1:0] OP_PUT   = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // character codes
   localparam logic [7:0] CH_BS        = 8'h08;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_PRINT_END = 8'h7F;
   localparam logic [7:0] CH_NUL       = 8'h00;

   // register index
   localparam logic REG_TEXT_ATTR = 1'b0;
   localparam int   CSR_AW        = 3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_MOVE,
      ST_BLANK,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic               char_we;
      logic               attr_we;
      logic [CELL_AW-1:0] addr;
      logic [7:0]         char_data;
      logic [7:0]         attr_data;
   } mem_wr_type;

   typedef struct packed {
      logic               char_we;
      logic               attr_we;
      logic [CELL_AW-1:0] addr;
      logic [7:0]         char_data;
      logic               scroll;
   } put_info_type;

   function automatic logic [CELL_AW-1:0] cell_index(input logic [ROW_W-1:0] row,
                                                     input logic [COL_W-1:0] col);
      logic [IDX_W-1:0] full;
      full = IDX_W'(row) * IDX_W'(COLUMNS) + IDX_W'(col);
      return full[CELL_AW-1:0];
   endfunction

endpackage

/* design/tcce_screen_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_screen_mem
// Character and attribute stores, one shared write port with byte enables
// and one registered read port.
// ----------------------------------------------------------------------------
module tcce_screen_mem (
   input  logic                        clock,
   input  tcce_pkg::mem_wr_type        wr,
   input  logic                        rd_en,
   input  logic [tcce_pkg::CELL_AW-1:0] rd_addr,
   output logic [7:0]                  rd_char,
   output logic [7:0]                  rd_attr
);

   logic [7:0] char_mem [0:tcce_pkg::SCREEN_CELLS-1];
   logic [7:0] attr_mem [0:tcce_pkg::SCREEN_CELLS-1];
   logic [7:0] rd_char_ff;
   logic [7:0] rd_attr_ff;

   always_ff @(posedge clock) begin
      if (wr.char_we) begin
         char_mem[wr.addr] <= wr.char_data;
      end
      if (wr.attr_we) begin
         attr_mem[wr.addr] <= wr.attr_data;
      end
      if (rd_en) begin
         rd_char_ff <= char_mem[rd_addr];
         rd_attr_ff <= attr_mem[rd_addr];
      end
   end

   assign rd_char = rd_char_ff;
   assign rd_attr = rd_attr_ff;

endmodule

/* design/tcce_cursor_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_cursor_unit
// Cursor position registers and the decode of one put character into the
// cell write, the new cursor and the scroll request.
// ----------------------------------------------------------------------------
module tcce_cursor_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      put_en,
   input  logic [7:0]                ch,
   output logic [tcce_pkg::COL_W-1:0] cur_col,
   output logic [tcce_pkg::ROW_W-1:0] cur_row,
   output tcce_pkg::put_info_type    put_info
);

   logic [tcce_pkg::COL_W-1:0] col_ff, col_in;
   logic [tcce_pkg::ROW_W-1:0] row_ff, row_in;
   logic [tcce_pkg::COL_W-1:0] col_step;
   logic [tcce_pkg::ROW_W-1:0] row_step;

   always_comb begin
      col_step          = col_ff;
      row_step          = row_ff;
      put_info.char_we  = 1'b0;
      put_info.attr_we  = 1'b0;
      put_info.addr     = tcce_pkg::cell_index(row_ff, col_ff);
      put_info.char_data = ch;
      put_info.scroll   = 1'b0;

      if (ch == tcce_pkg::CH_BS) begin
         if (col_ff > tcce_pkg::COL_W'(1)) begin
            put_info.char_we   = 1'b1;
            put_info.addr      = tcce_pkg::cell_index(row_ff, col_ff - tcce_pkg::COL_W'(1));
            put_info.char_data = tcce_pkg::CH_NUL;
            col_step           = col_ff - tcce_pkg::COL_W'(1);
         end
      end else if (ch == tcce_pkg::CH_TAB) begin
         col_step = (col_ff + tcce_pkg::COL_W'(tcce_pkg::TAB_STOP))
                    & ~tcce_pkg::COL_W'(tcce_pkg::TAB_STOP - 1);
      end else if (ch == tcce_pkg::CH_CR) begin
         col_step = '0;
      end else if (ch == tcce_pkg::CH_LF) begin
         col_step = tcce_pkg::COL_W'(1);
         row_step = row_ff + tcce_pkg::ROW_W'(1);
      end else if (ch inside {[tcce_pkg::CH_SPACE:tcce_pkg::CH_PRINT_END]}) begin
         put_info.char_we = 1'b1;
         put_info.attr_we = 1'b1;
         col_step         = col_ff + tcce_pkg::COL_W'(1);
      end

      // wrap past the last column, and request a scroll past the last row
      col_in = col_step;
      row_in = row_step;
      if (col_step >= tcce_pkg::COL_W'(tcce_pkg::COLUMNS)) begin
         col_in = tcce_pkg::COL_W'(1);
         row_in = row_step + tcce_pkg::ROW_W'(1);
      end
      if (row_in >= tcce_pkg::ROW_W'(tcce_pkg::SCROLL_ROWS)) begin
         row_in          = tcce_pkg::ROW_W'(tcce_pkg::SCROLL_ROWS - 1);
         put_info.scroll = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= tcce_pkg::ROW_W'(1);
      end else if (put_en) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign cur_col = col_ff;
   assign cur_row = row_ff;

endmodule

/* design/text_console_cursor_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_engine
// Text screen store with a cursor: put character, read cell, clear screen.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its result appears
// on the rsp_ ports for one cycle with rsp_valid and cannot be held off by
// the receiver. Put without scroll, read and unused op codes go straight
// from the request to the result state and then back to idle.
// A put that scrolls walks the character store through the write port and
// the read port: it moves the rows up, blanks the last row of the scroll
// area, then gives its result. Clear writes every one of the 2000 cells,
// one a cycle, then gives its result. After reset a clearing pass over all
// 2000 cells runs with busy high and no result; register writes are taken
// at any time.
// ----------------------------------------------------------------------------
module text_console_cursor_engine (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_op,
   input  logic [7:0]                         req_ch,
   input  logic [tcce_pkg::CELL_AW-1:0]        req_cell_addr,
   input  logic [7:0]                         req_fill_attr,
   // result channel
   output logic                               rsp_valid,
   output logic [tcce_pkg::COL_W-1:0]          rsp_cursor_col,
   output logic [tcce_pkg::ROW_W-1:0]          rsp_cursor_row,
   output logic [tcce_pkg::CELL_AW-1:0]        rsp_cursor_location,
   output logic [7:0]                         rsp_read_char,
   output logic [7:0]                         rsp_read_attr,
   // register port
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [tcce_pkg::CSR_AW-1:0]         paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);

   tcce_pkg::state_type         state_ff, state_in;
   logic [tcce_pkg::CELL_AW-1:0] cnt_ff, cnt_in;
   logic [7:0]                  fill_ff;
   logic [7:0]                  text_attr_ff;
   logic                        init_done_ff;
   logic                        rd_sel_ff;

   logic                        accept;
   logic                        put_en;
   logic                        addr_ok;
   logic                        csr_idx;
   logic                        csr_wr;

   tcce_pkg::mem_wr_type         mem_wr;
   logic                        mem_rd_en;
   logic [tcce_pkg::CELL_AW-1:0] mem_rd_addr;
   logic [7:0]                  mem_rd_char;
   logic [7:0]                  mem_rd_attr;

   logic [tcce_pkg::COL_W-1:0]   cur_col;
   logic [tcce_pkg::ROW_W-1:0]   cur_row;
   tcce_pkg::put_info_type       put_info;

   assign busy    = (state_ff != tcce_pkg::ST_IDLE);
   assign accept  = start && !busy;
   assign put_en  = accept && (req_op == tcce_pkg::OP_PUT);
   assign addr_ok = (req_cell_addr < tcce_pkg::CELL_AW'(tcce_pkg::SCREEN_CELLS));

   tcce_cursor_unit u_cursor (
      .clock    (clock),
      .reset    (reset),
      .put_en   (put_en),
      .ch       (req_ch),
      .cur_col  (cur_col),
      .cur_row  (cur_row),
      .put_info (put_info)
   );

   tcce_screen_mem u_mem (
      .clock   (clock),
      .wr      (mem_wr),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_char (mem_rd_char),
      .rd_attr (mem_rd_attr)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tcce_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_op)
                  tcce_pkg::OP_PUT:   state_in = put_info.scroll ? tcce_pkg::ST_MOVE
                                                                 : tcce_pkg::ST_RESP;
                  tcce_pkg::OP_CLEAR: state_in = tcce_pkg::ST_CLEAR;
                  default:            state_in = tcce_pkg::ST_RESP;
               endcase
            end
         end
         tcce_pkg::ST_CLEAR: begin
            if (cnt_ff == tcce_pkg::CELL_AW'(tcce_pkg::LAST_CELL)) begin
               state_in = init_done_ff ? tcce_pkg::ST_RESP : tcce_pkg::ST_IDLE;
            end
         end
         tcce_pkg::ST_MOVE: begin
            if (cnt_ff == tcce_pkg::CELL_AW'(tcce_pkg::MOVE_CELLS)) begin
               state_in = tcce_pkg::ST_BLANK;
            end
         end
         tcce_pkg::ST_BLANK: begin
            if (cnt_ff == tcce_pkg::CELL_AW'(tcce_pkg::BLANK_END)) begin
               state_in = tcce_pkg::ST_RESP;
            end
         end
         tcce_pkg::ST_RESP: state_in = tcce_pkg::ST_IDLE;
         default:           state_in = tcce_pkg::ST_IDLE;
      endcase
   end

   // memory port and sweep counter
   always_comb begin
      mem_wr      = '0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = req_cell_addr;
      cnt_in      = cnt_ff + tcce_pkg::CELL_AW'(1);
      case (state_ff)
         tcce_pkg::ST_IDLE: begin
            cnt_in = '0;
            if (put_en) begin
               mem_wr.char_we   = put_info.char_we;
               mem_wr.attr_we   = put_info.attr_we;
               mem_wr.addr      = put_info.addr;
               mem_wr.char_data = put_info.char_data;
               mem_wr.attr_data = text_attr_ff;
            end
            mem_rd_en = accept && (req_op == tcce_pkg::OP_READ) && addr_ok;
         end
         tcce_pkg::ST_CLEAR: begin
            mem_wr.char_we   = 1'b1;
            mem_wr.attr_we   = 1'b1;
            mem_wr.addr      = cnt_ff;
            mem_wr.char_data = tcce_pkg::CH_NUL;
            mem_wr.attr_data = fill_ff;
         end
         tcce_pkg::ST_MOVE: begin
            // read one row below, write back what the previous cycle read
            mem_rd_en        = (cnt_ff < tcce_pkg::CELL_AW'(tcce_pkg::MOVE_CELLS));
            mem_rd_addr      = cnt_ff + tcce_pkg::CELL_AW'(tcce_pkg::COLUMNS);
            mem_wr.char_we   = (cnt_ff != '0);
            mem_wr.addr      = cnt_ff - tcce_pkg::CELL_AW'(1);
            mem_wr.char_data = mem_rd_char;
            if (cnt_ff == tcce_pkg::CELL_AW'(tcce_pkg::MOVE_CELLS)) begin
               cnt_in = cnt_ff;
            end
         end
         tcce_pkg::ST_BLANK: begin
            mem_wr.char_we   = 1'b1;
            mem_wr.addr      = cnt_ff;
            mem_wr.char_data = tcce_pkg::CH_SPACE;
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcce_pkg::ST_CLEAR;
         cnt_ff       <= '0;
         fill_ff      <= '0;
         init_done_ff <= 1'b0;
         rd_sel_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (accept) begin
            rd_sel_ff <= (req_op == tcce_pkg::OP_READ) && addr_ok;
            if (req_op == tcce_pkg::OP_CLEAR) begin
               fill_ff <= req_fill_attr;
            end
         end
         // the power-up clear ends without a result
         if ((state_ff == tcce_pkg::ST_CLEAR)
             && (cnt_ff == tcce_pkg::CELL_AW'(tcce_pkg::LAST_CELL))) begin
            init_done_ff <= 1'b1;
         end
      end
   end

   // register port
   assign csr_idx = paddr[tcce_pkg::CSR_AW-1];
   assign csr_wr  = psel && penable && pwrite && pready;
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         text_attr_ff <= 8'd7;
      end else if (csr_wr && (csr_idx == tcce_pkg::REG_TEXT_ATTR)) begin
         text_attr_ff <= pwdata[7:0];
      end
   end

   assign prdata = (csr_idx == tcce_pkg::REG_TEXT_ATTR) ? {24'd0, text_attr_ff} : 32'd0;

   // result
   assign rsp_valid           = (state_ff == tcce_pkg::ST_RESP);
   assign rsp_cursor_col      = cur_col;
   assign rsp_cursor_row      = cur_row;
   assign rsp_cursor_location = tcce_pkg::cell_index(cur_row, cur_col);
   assign rsp_read_char       = rd_sel_ff ? mem_rd_char : 8'd0;
   assign rsp_read_attr       = rd_sel_ff ? mem_rd_attr : 8'd0;

   a_rsp_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("engine not busy after taking a request");

   a_cursor_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cursor_col < tcce_pkg::COL_W'(tcce_pkg::COLUMNS)
                     && rsp_cursor_row < tcce_pkg::ROW_W'(tcce_pkg::SCROLL_ROWS)))
      else $error("cursor outside the scroll area");

endmodule
